FILE: hdl/jaa_pkg.sv
// ----------------------------------------------------------------------------
// Jet angularity accumulator package
// Shared payload types and fixed-point constants.
// ----------------------------------------------------------------------------
package jaa_pkg;

  localparam logic [14:0] Pi    = 15'd12868;
  localparam logic [15:0] TwoPi = 16'd25736;
  localparam logic [13:0] RadiusReset = 14'd1638;

  typedef struct packed {
    logic [19:0]        jet_pt;
    logic signed [15:0] jet_eta;
    logic [14:0]        jet_phi;
    logic [19:0]        part_pt;
    logic signed [15:0] part_eta;
    logic [14:0]        part_phi;
    logic               charged;
    logic               last_part;
  } in_item_t;

  typedef struct packed {
    logic [23:0] ang_r1;
    logic [23:0] ang_r05;
    logic [23:0] ang_r15;
    logic [23:0] ang_r2;
    logic [23:0] ang_r3;
    logic [23:0] disp_z2;
  } out_item_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic [19:0] jet_pt;
    logic [19:0] part_pt;
    logic [33:0] d2;
    logic        charged;
    logic        last_part;
  } job_t;

endpackage

FILE: hdl/jaa_front.sv
// ----------------------------------------------------------------------------
// Jet angularity front end
// Accepts constituents, wraps the phi difference and forms the squared
// distance, then queues a job for the back end.
// ----------------------------------------------------------------------------
module jaa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  jaa_pkg::in_item_t in_data_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output jaa_pkg::job_t     job_o
);

  jaa_pkg::job_t mem_q [2];
  logic [0:0] wr_q, rd_q;
  logic [1:0] cnt_q;
  jaa_pkg::job_t job_new;
  logic signed [17:0] deta, dphi0, dphi1, dphi2, dphi3;
  logic [35:0] de2, dp2;
  logic do_push, do_pop;

  function automatic logic signed [17:0] wrap(input logic signed [17:0] v);
    if (v > $signed({3'd0, jaa_pkg::Pi})) begin
      wrap = v - $signed({2'd0, jaa_pkg::TwoPi});
    end else if (v < -$signed({3'd0, jaa_pkg::Pi})) begin
      wrap = v + $signed({2'd0, jaa_pkg::TwoPi});
    end else begin
      wrap = v;
    end
  endfunction

  always_comb begin
    deta  = 18'(in_data_i.jet_eta) - 18'(in_data_i.part_eta);
    dphi0 = $signed({3'd0, in_data_i.jet_phi}) - $signed({3'd0, in_data_i.part_phi});
    dphi1 = wrap(dphi0);
    dphi2 = wrap(dphi1);
    dphi3 = wrap(dphi2);
    de2 = 36'(36'(deta) * 36'(deta));
    dp2 = 36'(36'(dphi3) * 36'(dphi3));
    job_new.jet_pt    = in_data_i.jet_pt;
    job_new.part_pt   = in_data_i.part_pt;
    job_new.d2        = 34'(de2 + dp2);
    job_new.charged   = in_data_i.charged;
    job_new.last_part = in_data_i.last_part;
  end

  assign full        = cnt_q == 2'd2;
  assign job_valid_o = cnt_q != 2'd0;
  assign job_o       = mem_q[rd_q];
  assign do_push     = push && !full;
  assign do_pop      = job_valid_o && job_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count out of range");
  a_full_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full && !do_pop |=> cnt_q == 2'd2) else $error("full queue changed count");
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !do_pop) else $error("pop from empty queue");
`endif

endmodule

FILE: hdl/jaa_back.sv
// ----------------------------------------------------------------------------
// Jet angularity back end
// Sequencer with one shared divider, one square-root unit and one 32x32
// multiplier; accumulates six sums and hands results to a result register.
// ----------------------------------------------------------------------------
module jaa_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [13:0]        radius_i,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  jaa_pkg::job_t      job_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output jaa_pkg::out_item_t res_o
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_DIVZ = 10'b0000000010,
    S_SQDR = 10'b0000000100,
    S_DIVR = 10'b0000001000,
    S_SQR  = 10'b0000010000,
    S_MUL  = 10'b0000100000,
    S_EMIT = 10'b0001000000,
    S_WAIT = 10'b0010000000,
    S_SETR = 10'b0100000000,
    S_SETS = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  jaa_pkg::job_t job_q;
  logic [39:0] sums_q [6];

  // Shared restoring divider: 48-bit dividend, 20-bit divisor.
  logic [47:0] dq_q;   // dividend shifting into quotient
  logic [20:0] rem_q;
  logic [19:0] dvs_q;
  logic [5:0]  cnt_q;
  // Square-root unit: 42-bit radicand, two bits per step.
  logic [43:0] sres_q;
  logic [43:0] sbit_q;
  logic [43:0] srem_q;

  logic [23:0] z_q, r_q, sr_q;
  logic [31:0] r2_q;
  logic [31:0] r15_q;
  logic [3:0]  mstep_q;
  logic [31:0] ma, mb;
  logic [63:0] mp_q;
  logic        mp_v_q;
  logic [3:0]  mtag_q;
  logic [2:0]  osel_q;

  logic [21:0] rem_try;
  logic [44:0] stry;
  logic [48:0] s_sum;
  logic [31:0] p16;

  assign job_ready_o = state_q == S_IDLE;
  assign rem_try = {rem_q, dq_q[47]} - {2'b0, dvs_q};
  assign stry = {1'b0, srem_q} - ({1'b0, sres_q} + {1'b0, sbit_q});
  assign p16 = (mp_q[63:48] != 16'd0) ? 32'hFFFFFFFF : mp_q[47:16];

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (mstep_q)
      4'd0: begin ma = {8'd0, z_q}; mb = {8'd0, r_q}; end
      4'd1: begin ma = {8'd0, z_q}; mb = {8'd0, sr_q}; end
      4'd2: begin ma = {8'd0, r_q}; mb = {8'd0, sr_q}; end
      4'd3: begin ma = {8'd0, r_q}; mb = {8'd0, r_q}; end
      4'd4: begin ma = {8'd0, z_q}; mb = {8'd0, z_q}; end
      4'd5: begin ma = r2_q; mb = {8'd0, r_q}; end
      4'd6: begin ma = {8'd0, z_q}; mb = r2_q; end
      4'd7: begin ma = {8'd0, z_q}; mb = r2_q; end
      4'd8: begin ma = {8'd0, z_q}; mb = r15_q; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (job_valid_i) state_d = job_i.charged ? S_DIVZ : S_EMIT;
      S_DIVZ: if (cnt_q == 6'd0) state_d = S_SQDR;
      S_SQDR: if (sbit_q == 44'd0) state_d = S_DIVR;
      S_DIVR: if (cnt_q == 6'd0) state_d = S_SETR;
      S_SETR: state_d = S_SQR;
      S_SQR:  if (sbit_q == 44'd0) state_d = S_SETS;
      S_SETS: state_d = S_MUL;
      S_MUL:  if (mstep_q == 4'd9 && !mp_v_q) state_d = S_EMIT;
      S_EMIT: state_d = job_q.last_part ? S_WAIT : S_IDLE;
      S_WAIT: if (!res_valid_o || res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int k = 0; k < 6; k++) sums_q[k] <= '0;
      res_valid_o <= 1'b0;
      mstep_q <= '0;
      mp_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mp_v_q <= state_q == S_MUL && mstep_q != 4'd9;
      if (state_q == S_SETS) begin
        mstep_q <= '0;
      end else if (state_q == S_MUL && mstep_q != 4'd9) begin
        mstep_q <= mstep_q + 4'd1;
      end
      if (mp_v_q && (mtag_q == 4'd0 || mtag_q == 4'd1 || mtag_q == 4'd4 ||
                     mtag_q == 4'd6 || mtag_q == 4'd7 || mtag_q == 4'd8)) begin
        sums_q[osel_q] <= s_sum[48:40] != 9'd0 ? 40'hFFFFFFFFFF : s_sum[39:0];
      end
      if (state_q == S_WAIT && (!res_valid_o || res_ready_i)) begin
        res_valid_o <= 1'b1;
        for (int k = 0; k < 6; k++) sums_q[k] <= '0;
      end else if (res_valid_o && res_ready_i) begin
        res_valid_o <= 1'b0;
      end
    end
  end

  always_comb begin
    unique case (mtag_q)
      4'd0: osel_q = 3'd0;
      4'd1: osel_q = 3'd1;
      4'd4: osel_q = 3'd5;
      4'd6: osel_q = 3'd3;
      4'd7: osel_q = 3'd4;
      default: osel_q = 3'd2;
    endcase
    s_sum = 49'(sums_q[osel_q]) + 49'(mp_q[63:16]);
  end

  function automatic logic [23:0] sat24(input logic [47:0] v);
    sat24 = (v[47:24] != 24'd0) ? 24'hFFFFFF : v[23:0];
  endfunction

  always_ff @(posedge clk_i) begin
    mp_q <= ma * mb;
    mtag_q <= mstep_q;
    if (state_q == S_IDLE && job_valid_i) begin
      job_q <= job_i;
      dq_q <= {12'd0, job_i.part_pt, 16'd0};
      rem_q <= '0;
      dvs_q <= job_i.jet_pt;
      cnt_q <= 6'd48;
      srem_q <= {2'd0, job_i.d2, 8'd0};
      sres_q <= '0;
      sbit_q <= 44'd1 << 42;
    end
    if (state_q == S_DIVZ || state_q == S_DIVR) begin
      if (cnt_q != 6'd0) begin
        cnt_q <= cnt_q - 6'd1;
        if (!rem_try[21]) begin
          rem_q <= rem_try[20:0];
          dq_q <= {dq_q[46:0], 1'b1};
        end else begin
          rem_q <= {rem_q[19:0], dq_q[47]};
          dq_q <= {dq_q[46:0], 1'b0};
        end
      end else if (state_q == S_DIVZ) begin
        z_q <= (job_q.jet_pt == 20'd0) ? 24'hFFFFFF : sat24(dq_q);
      end
    end
    if (state_q == S_SQDR || state_q == S_SQR) begin
      if (sbit_q != 44'd0) begin
        if (!stry[44]) begin
          srem_q <= stry[43:0];
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end else if (state_q == S_SQDR) begin
        // deltaR below 2^21; divide (dr << 12) by the radius.
        dq_q <= {15'd0, sres_q[20:0], 12'd0};
        rem_q <= '0;
        dvs_q <= {6'd0, radius_i};
        cnt_q <= 6'd48;
      end else begin
        sr_q <= {4'd0, sres_q[19:0]};
      end
    end
    if (state_q == S_SETR) begin
      r_q <= (radius_i == 14'd0) ? 24'hFFFFFF : sat24(dq_q);
      srem_q <= {4'd0, (radius_i == 14'd0) ? 24'hFFFFFF : sat24(dq_q), 16'd0};
      sres_q <= '0;
      sbit_q <= 44'd1 << 42;
    end
    if (mp_v_q && mtag_q == 4'd2) r15_q <= p16;
    if (mp_v_q && mtag_q == 4'd3) r2_q <= p16;
    if (mp_v_q && mtag_q == 4'd5) r2_q <= p16;
    if (state_q == S_WAIT && (!res_valid_o || res_ready_i)) begin
      res_o.ang_r1  <= sat24(sums_q[0][39:0] > 40'hFFFFFF ? 48'hFFFFFF : 48'(sums_q[0]));
      res_o.ang_r05 <= sat24(48'(sums_q[1]));
      res_o.ang_r15 <= sat24(48'(sums_q[2]));
      res_o.ang_r2  <= sat24(48'(sums_q[3]));
      res_o.ang_r3  <= sat24(48'(sums_q[4]));
      res_o.disp_z2 <= sat24(48'(sums_q[5]));
    end
  end

`ifndef SYNTHESIS
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_ready_o |-> state_q == S_IDLE) else $error("ready outside idle");
  a_wait_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WAIT && res_valid_o && !res_ready_i |=> state_q == S_WAIT)
    else $error("result overwritten");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
`endif

endmodule

FILE: hdl/jet_angularity_accumulator_core.sv
// ----------------------------------------------------------------------------
// Jet angularity accumulator core
// Top level: front end with a two-entry job queue, sequenced back end.
// ----------------------------------------------------------------------------
// A charged constituent occupies the back end through the bit-serial divider
// (two 48-step divisions), the two-bits-per-step square-root unit (two 22-step
// roots) and nine multiplier steps; a neutral one skips them, and one that
// closes the jet also passes the wait state. A pushed constituent is written
// into the front-end queue before it reaches the back end, the front end
// queues up to two constituents meanwhile, and a finished jet waits in a
// one-entry result register until it is popped.
module jet_angularity_accumulator_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [13:0]        cfg_data_i,
  input  logic               push,
  output logic               full,
  input  jaa_pkg::in_item_t  in_data_i,
  output logic               empty,
  input  logic               pop,
  output jaa_pkg::out_item_t out_data_o
);

  logic [13:0] radius_q;
  logic job_valid, job_ready, res_valid;
  jaa_pkg::job_t job;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= jaa_pkg::RadiusReset;
    end else if (cfg_valid_i) begin
      radius_q <= cfg_data_i;
    end
  end

  jaa_front u_front (
    .clk_i, .rst_ni, .push, .full, .in_data_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  jaa_back u_back (
    .clk_i, .rst_ni, .radius_i(radius_q),
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .res_valid_o(res_valid), .res_ready_i(pop), .res_o(out_data_o)
  );

  assign empty = !res_valid;

endmodule

FILE: verif/jet_angularity_accumulator_core_test.sv
// ----------------------------------------------------------------------------
// Jet angularity accumulator core testbench
// Drives constituent streams through the push/full side, pops the six
// saturated angularity sums and compares them with a built-in predictor.
// ----------------------------------------------------------------------------
module jet_angularity_accumulator_core_test;

  localparam int PiQ = 12868;
  localparam int TwoPiQ = 25736;
  localparam longint unsigned Clamp24 = 64'hFFFFFF;
  localparam longint unsigned Clamp32 = 64'hFFFFFFFF;
  localparam longint unsigned SumMax = 64'hFFFFFFFFFF;
  localparam int NumDirected = 14;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [13:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  jaa_pkg::in_item_t in_data_i = '0;
  logic empty;
  logic pop = 1'b0;
  jaa_pkg::out_item_t out_data_o;

  longint unsigned angle_sums [6];
  logic [13:0] radius_q;
  jaa_pkg::out_item_t sums_expected [$];
  int errors = 0;
  int jets_seen = 0;
  int items_sent = 0;
  int send_idle = 0;
  int take_idle = 0;

  jaa_pkg::in_item_t stim_tab [NumDirected];
  logic stim_has_exp [NumDirected];
  jaa_pkg::out_item_t stim_exp [NumDirected];

  jet_angularity_accumulator_core DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned clip(longint unsigned v, longint unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  task automatic accumulate_angularity(input jaa_pkg::in_item_t it);
    longint signed deta, dphi;
    longint unsigned z, r, dr, sr, r15, r2, r3, d2;
    longint unsigned terms [6];
    jaa_pkg::out_item_t res;
    if (it.charged) begin
      deta = longint'(it.jet_eta) - longint'(it.part_eta);
      dphi = longint'(it.jet_phi) - longint'(it.part_phi);
      for (int i = 0; i < 3; i++) begin
        if (dphi > PiQ) dphi -= TwoPiQ;
        else if (dphi < -PiQ) dphi += TwoPiQ;
      end
      z = (it.jet_pt == 0) ? Clamp24
          : clip((longint'(it.part_pt) << 16) / it.jet_pt, Clamp24);
      d2 = deta * deta + dphi * dphi;
      dr = int_sqrt(d2 << 8);
      r = (radius_q == 0) ? Clamp24 : clip((dr << 12) / radius_q, Clamp24);
      sr = int_sqrt(r << 16);
      r15 = clip((r * sr) >> 16, Clamp32);
      r2 = clip((r * r) >> 16, Clamp32);
      r3 = clip((r2 * r) >> 16, Clamp32);
      terms[0] = (z * r) >> 16;
      terms[1] = (z * sr) >> 16;
      terms[2] = (z * r15) >> 16;
      terms[3] = (z * r2) >> 16;
      terms[4] = (z * r3) >> 16;
      terms[5] = (z * z) >> 16;
      for (int k = 0; k < 6; k++) angle_sums[k] = clip(angle_sums[k] + terms[k], SumMax);
    end
    if (it.last_part) begin
      res.ang_r1 = 24'(clip(angle_sums[0], Clamp24));
      res.ang_r05 = 24'(clip(angle_sums[1], Clamp24));
      res.ang_r15 = 24'(clip(angle_sums[2], Clamp24));
      res.ang_r2 = 24'(clip(angle_sums[3], Clamp24));
      res.ang_r3 = 24'(clip(angle_sums[4], Clamp24));
      res.disp_z2 = 24'(clip(angle_sums[5], Clamp24));
      sums_expected = {sums_expected, res};
      for (int k = 0; k < 6; k++) angle_sums[k] = 0;
    end
  endtask

  task automatic push_item(input jaa_pkg::in_item_t it);
    if ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    push <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    accumulate_angularity(it);
    items_sent++;
  endtask

  task automatic drain_and_settle();
    int waited;
    waited = 0;
    push <= 1'b0;
    while (sums_expected.size() != 0 && waited < 2000000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [13:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    radius_q = value;
  endtask

  function automatic jaa_pkg::in_item_t random_item(input logic last_one);
    jaa_pkg::in_item_t it;
    int sel;
    sel = $urandom_range(9);
    it.jet_pt = (sel == 0) ? 20'($urandom) : 20'($urandom_range(1048575, 1024));
    it.jet_eta = 16'($urandom_range(34406) - 17203);
    it.jet_phi = 15'($urandom_range(25736));
    it.part_pt = (sel < 2) ? 20'($urandom) : 20'($urandom_range(it.jet_pt));
    it.part_eta = (sel == 1) ? 16'($urandom)
                  : 16'(int'(it.jet_eta) + $urandom_range(4000) - 2000);
    it.part_phi = (sel == 2) ? 15'($urandom) : 15'($urandom_range(25736));
    it.charged = ($urandom_range(3) != 0);
    it.last_part = last_one;
    return it;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (sums_expected.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        jaa_pkg::out_item_t e;
        e = sums_expected.pop_front();
        jets_seen++;
        if (out_data_o.ang_r1 !== e.ang_r1) begin
          $error("ang_r1 exp %0h got %0h", e.ang_r1, out_data_o.ang_r1); errors++;
        end
        if (out_data_o.ang_r05 !== e.ang_r05) begin
          $error("ang_r05 exp %0h got %0h", e.ang_r05, out_data_o.ang_r05); errors++;
        end
        if (out_data_o.ang_r15 !== e.ang_r15) begin
          $error("ang_r15 exp %0h got %0h", e.ang_r15, out_data_o.ang_r15); errors++;
        end
        if (out_data_o.ang_r2 !== e.ang_r2) begin
          $error("ang_r2 exp %0h got %0h", e.ang_r2, out_data_o.ang_r2); errors++;
        end
        if (out_data_o.ang_r3 !== e.ang_r3) begin
          $error("ang_r3 exp %0h got %0h", e.ang_r3, out_data_o.ang_r3); errors++;
        end
        if (out_data_o.disp_z2 !== e.disp_z2) begin
          $error("disp_z2 exp %0h got %0h", e.disp_z2, out_data_o.disp_z2); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= take_idle);
  end

  initial begin
    #400000000;
    $display("jet_angularity_accumulator_core test failed");
    $finish;
  end

  initial begin
    logic [13:0] radii [4];
    radii = '{14'd410, 14'd8192, 14'd16383, 14'd0};
    // Directed rows: jet_pt, jet_eta, jet_phi, part_pt, part_eta, part_phi, charged, last.
    stim_tab = '{
      '{20'd1024, 16'sd0, 15'd0, 20'd1024, 16'sd0, 15'd0, 1'b1, 1'b1},
      '{20'd1024, 16'sd0, 15'd100, 20'd0, 16'sd0, 15'd100, 1'b1, 1'b1},
      '{20'd1024, 16'sd0, 15'd0, 20'd512, 16'sd0, 15'd0, 1'b0, 1'b1},
      '{20'd0, 16'sd17203, 15'd25736, 20'd1048575, -16'sd17203, 15'd0, 1'b1, 1'b0},
      '{20'd1, 16'sd0, 15'd0, 20'd1048575, 16'sd0, 15'd0, 1'b1, 1'b1},
      '{20'd1048575, 16'sd0, 15'd25000, 20'd1048575, 16'sd0, 15'd100, 1'b1, 1'b1},
      '{20'd1048575, -16'sd17203, 15'd0, 20'd1, 16'sd17203, 15'd25736, 1'b1, 1'b1},
      '{20'd2048, 16'sd32767, 15'd32767, 20'd1024, 16'sh8000, 15'd0, 1'b1, 1'b1},
      '{20'd2048, 16'sh8000, 15'd0, 20'd1024, 16'sd32767, 15'd32767, 1'b1, 1'b0},
      '{20'd2048, 16'sd100, 15'd12868, 20'd2048, 16'sd0, 15'd0, 1'b1, 1'b0},
      '{20'd2048, 16'sd100, 15'd0, 20'd2048, 16'sd0, 15'd12869, 1'b1, 1'b1},
      '{20'd4096, 16'sd500, 15'd300, 20'd1000, 16'sd200, 15'd900, 1'b0, 1'b0},
      '{20'd4096, 16'sd500, 15'd300, 20'd1000, 16'sd200, 15'd900, 1'b1, 1'b0},
      '{20'd4096, 16'sd500, 15'd300, 20'd1000, 16'sd200, 15'd900, 1'b0, 1'b1}
    };
    stim_has_exp = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                     1'b0, 1'b0, 1'b0, 1'b0};
    stim_exp[0] = '{ang_r1: 0, ang_r05: 0, ang_r15: 0, ang_r2: 0, ang_r3: 0,
                    disp_z2: 24'h10000};
    stim_exp[1] = '0;
    stim_exp[2] = '0;
    for (int k = 0; k < 6; k++) angle_sums[k] = 0;
    radius_q = jaa_pkg::RadiusReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    take_idle = 51;
    send_idle = 12;
    for (int i = 0; i < NumDirected; i++) begin
      push_item(stim_tab[i]);
      if (stim_has_exp[i] && sums_expected[$] !== stim_exp[i]) begin
        $error("predictor row %0d disagrees with typed result", i);
        errors++;
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      drain_and_settle();
      write_radius(phase == 3 ? 14'($urandom_range(8192, 410)) : radii[phase]);
      if (phase == 1) begin
        send_idle = 51;
        take_idle = 12;
      end else if (phase == 2) begin
        send_idle = 0;
        take_idle = 0;
      end
      for (int n = 0; n < 300; ) begin
        int jet_len;
        jaa_pkg::in_item_t axis;
        jet_len = $urandom_range(8, 1);
        axis = random_item(1'b0);
        for (int j = 0; j < jet_len; j++) begin
          jaa_pkg::in_item_t it;
          it = random_item(j == jet_len - 1);
          if ($urandom_range(9) != 0) begin
            it.jet_pt = axis.jet_pt;
            it.jet_eta = axis.jet_eta;
            it.jet_phi = axis.jet_phi;
          end
          push_item(it);
          n++;
        end
      end
    end
    drain_and_settle();
    write_radius(jaa_pkg::RadiusReset);

    if (sums_expected.size() != 0) begin
      $error("%0d results never arrived", sums_expected.size());
      errors++;
    end
    $display("Sent %0d constituents, checked %0d jet results over 5 radius settings.",
             items_sent, jets_seen);
    if (errors == 0) begin
      $display("jet_angularity_accumulator_core test passed");
    end else begin
      $display("jet_angularity_accumulator_core test failed");
    end
    $finish;
  end

endmodule
